FILE: design/sdi12_run_length_receiver_unit_defines.svh
// Assertion macros shared by the receiver RTL.
`ifndef SDI12_RUN_LENGTH_RECEIVER_UNIT_DEFINES_SVH
`define SDI12_RUN_LENGTH_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SDI12_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define SDI12_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/sdi12_rlr_pkg.sv
// Types and constants for the SDI-12 run-length receiver.
package sdi12_rlr_pkg;

  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned RUN_CAP   = 90;
  localparam int unsigned DIV_STEPS = 18;

  localparam logic [6:0] CR_CHAR    = 7'h0D;
  localparam logic [7:0] ABORT_BYTE = 8'hFF;

  localparam logic [15:0] PERIOD_RESET  = 16'd833;
  localparam logic [9:0]  TIMEOUT_RESET = 10'd395;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_CHAR     = 3'd0,
    KIND_CR_END   = 3'd1,
    KIND_ABORT    = 3'd2,
    KIND_TIMEOUT  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  localparam logic CFG_PERIOD  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

endpackage

FILE: design/sdi12_run_length_receiver_unit.sv
// SDI-12 reply receiver: line runs in, decoded characters out.
//
// Input channel (in_valid/in_ready) takes one beat per command: func 0 starts
// a reply, func 1 is a line run (line_level, duration_us), func 2 a 1 ms tick.
// Output channel (out_valid/out_ready) gives one beat per completed frame or
// timeout; last marks the final beat caused by an input beat.
// Config port: cfg_we writes cfg_data to register cfg_addr (0 bit period in
// us, 1 reply timeout in ms) in the same cycle; write only while idle.
// Sequence: start, tick and ignored beats are handled in ST_IDLE. A run is
// accepted, passes through the restoring divider (one quotient bit per
// cycle), then fills frames in chunks of up to 10 bits. A timeout result is
// posted from ST_TOUT.
// Results go through a single output register; the sequencer stalls on a
// completed frame or timeout while that register is held by the receiver,
// and in_ready stays low until the run is fully consumed. A start may be
// accepted while an earlier result still waits.
// Reset clears the sequencer and output register, loads the default bit
// period and timeout, and leaves the receiver idle until a start beat.
`include "sdi12_run_length_receiver_unit_defines.svh"

module sdi12_run_length_receiver_unit #(
  parameter int MAX_CHARS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic        line_level,
  input  logic [15:0] duration_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [6:0]  character,
  output logic [7:0]  raw_byte,
  output logic [5:0]  char_index,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);
  import sdi12_rlr_pkg::*;

  localparam int CW = $clog2(MAX_CHARS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FILL,
    ST_TOUT
  } state_t;

  state_t       state;
  logic [15:0]  bit_period_us;
  logic [9:0]   reply_timeout_ms;
  logic [9:0]   frame_bits;
  logic [3:0]   bit_pos;
  logic [CW-1:0] chars_received;
  logic [9:0]   elapsed_ms;
  logic         reply_done;
  logic         run_level;
  logic [17:0]  div_q;
  logic [17:0]  div_rem;
  logic [16:0]  div_den;
  logic [4:0]   div_cnt;
  logic [6:0]   rem_bits;

  // combinational helpers
  logic         in_fire;
  logic         slot_free;
  logic         posting;
  logic [15:0]  period_eff;
  logic [10:0]  elapsed_next;
  logic [17:0]  rem_shift;
  logic         sub_ok;
  logic [17:0]  q_next;
  logic [6:0]   q_capped;
  logic [3:0]   avail;
  logic [3:0]   chunk;
  logic [4:0]   pos_end;
  logic [9:0]   fill_mask;
  logic [9:0]   frame_next;
  logic [7:0]   f_raw;
  logic [6:0]   f_char;
  kind_t        f_kind;
  logic [6:0]   rem_after;
  logic         frame_done;
  logic [CW+5:0] chars_ext;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign chars_ext = {6'd0, chars_received};

  always_comb begin
    period_eff   = (bit_period_us == 16'd0) ? 16'd1 : bit_period_us;
    elapsed_next = {1'b0, elapsed_ms} + 11'd1;

    // one restoring-division step
    rem_shift = {div_rem[16:0], div_q[17]};
    sub_ok    = (rem_shift >= {1'b0, div_den});
    q_next    = {div_q[16:0], sub_ok};
    q_capped  = (q_next > 18'(RUN_CAP)) ? 7'(RUN_CAP) : q_next[6:0];

    // fill as many bits of the current frame as the run still has
    avail   = 4'(FRAME_LEN) - bit_pos;
    chunk   = (rem_bits < {3'd0, avail}) ? rem_bits[3:0] : avail;
    pos_end = {1'b0, bit_pos} + {1'b0, chunk};
    for (int i = 0; i < 10; i++) begin
      fill_mask[i] = (5'(i) >= {1'b0, bit_pos}) && (5'(i) < pos_end);
    end
    frame_next = run_level ? (frame_bits | fill_mask) : frame_bits;
    frame_done = (pos_end == 5'(FRAME_LEN));
    rem_after  = rem_bits - {3'd0, chunk};

    f_raw  = frame_next[8:1];
    f_char = ~f_raw[6:0];
    if (chars_received >= CW'(MAX_CHARS)) begin
      f_kind = KIND_OVERFLOW;
    end else if (f_raw == ABORT_BYTE) begin
      f_kind = KIND_ABORT;
    end else if (f_char == CR_CHAR) begin
      f_kind = KIND_CR_END;
    end else begin
      f_kind = KIND_CHAR;
    end

    // a new result beat is loaded this cycle
    posting = slot_free && ((state == ST_TOUT) ||
              (state == ST_FILL && rem_bits != 7'd0 && frame_done));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      bit_period_us    <= PERIOD_RESET;
      reply_timeout_ms <= TIMEOUT_RESET;
      frame_bits       <= '0;
      bit_pos          <= '0;
      chars_received   <= '0;
      elapsed_ms       <= '0;
      reply_done       <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PERIOD:  bit_period_us    <= cfg_data;
          CFG_TIMEOUT: reply_timeout_ms <= cfg_data[9:0];
          default:     bit_period_us    <= bit_period_us;
        endcase
      end

      if (out_valid && out_ready && !posting) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            priority if (func_t'(func) == FUNC_START) begin
              frame_bits     <= '0;
              bit_pos        <= '0;
              chars_received <= '0;
              elapsed_ms     <= '0;
              reply_done     <= 1'b0;
            end else if (func_t'(func) == FUNC_NONE || reply_done) begin
              state <= ST_IDLE;
            end else if (func_t'(func) == FUNC_TICK) begin
              if (elapsed_next > {1'b0, reply_timeout_ms}) begin
                reply_done <= 1'b1;
                state      <= ST_TOUT;
              end else begin
                elapsed_ms <= elapsed_next[9:0];
              end
            end else begin
              run_level <= line_level;
              div_q     <= {1'b0, duration_us, 1'b0} + {2'b0, period_eff};
              div_rem   <= '0;
              div_den   <= {period_eff, 1'b0};
              div_cnt   <= '0;
              state     <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          div_q   <= q_next;
          div_rem <= sub_ok ? (rem_shift - {1'b0, div_den}) : rem_shift;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(DIV_STEPS - 1)) begin
            rem_bits <= q_capped;
            state    <= ST_FILL;
          end
        end

        ST_FILL: begin
          if (rem_bits == 7'd0) begin
            state <= ST_IDLE;
          end else if (!frame_done) begin
            frame_bits <= frame_next;
            bit_pos    <= pos_end[3:0];
            rem_bits   <= rem_after;
            state      <= ST_IDLE;
          end else if (slot_free) begin
            out_valid  <= 1'b1;
            kind       <= f_kind;
            character  <= f_char;
            raw_byte   <= f_raw;
            char_index <= chars_ext[5:0];
            last       <= (f_kind != KIND_CHAR) || (rem_after < 7'(FRAME_LEN));
            frame_bits <= '0;
            bit_pos    <= '0;
            rem_bits   <= rem_after;
            if (f_kind != KIND_OVERFLOW) begin
              chars_received <= chars_received + CW'(1);
            end
            if (f_kind != KIND_CHAR) begin
              reply_done <= 1'b1;
              state      <= ST_IDLE;
            end else if (rem_after == 7'd0) begin
              state <= ST_IDLE;
            end
          end
        end

        ST_TOUT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            kind       <= KIND_TIMEOUT;
            character  <= '0;
            raw_byte   <= '0;
            char_index <= chars_ext[5:0];
            last       <= 1'b1;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  `SDI12_ASSERT_IMPLY(a_pos_in_frame, 1'b1, bit_pos < 4'(FRAME_LEN))
  `SDI12_ASSERT_IMPLY(a_chars_bounded, 1'b1, chars_received <= CW'(MAX_CHARS))
  `SDI12_ASSERT_IMPLY(a_end_is_last, out_valid && kind != KIND_CHAR, last)
  `SDI12_ASSERT_IMPLY(a_run_capped, state == ST_FILL, rem_bits <= 7'(RUN_CAP))
  `SDI12_ASSERT_NEXT(a_div_to_fill, state == ST_DIV && div_cnt == 5'(DIV_STEPS - 1),
                     state == ST_FILL)

endmodule
